[hdl/tplbt_pkg.sv]
`default_nettype none

package tplbt_pkg;

  // request kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_SEND = 2'd1;
  localparam logic [1:0] KIND_RECV = 2'd2;

  // transfer modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_SEND = 2'd1;
  localparam logic [1:0] MODE_RECV = 2'd2;

  // shared data shift register
  localparam int SHIFT_W     = 8;
  localparam int SHIFT_IDX_W = 3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [SHIFT_W-1:0] send_byte;
    logic               line_pin;
  } item_t;

  typedef struct packed {
    logic               drive_pin;
    logic [1:0]         busy_mode;
    logic [SHIFT_W-1:0] received_byte;
    logic               received_done;
  } result_t;

endpackage

`default_nettype wire

[hdl/tplbt_if.sv]
`default_nettype none

// request channel into the transceiver
interface tplbt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] send_byte;
  logic       line_pin;

  modport source (output valid, kind, send_byte, line_pin, input ready);
  modport sink   (input valid, kind, send_byte, line_pin, output ready);
  modport mon    (input valid, ready, kind, send_byte, line_pin);
endinterface

// result channel out of the transceiver
interface tplbt_out_if;
  logic       valid;
  logic       ready;
  logic       drive_pin;
  logic [1:0] busy_mode;
  logic [7:0] received_byte;
  logic       received_done;

  modport source (output valid, drive_pin, busy_mode, received_byte, received_done,
                  input ready);
  modport sink   (input valid, drive_pin, busy_mode, received_byte, received_done,
                  output ready);
  modport mon    (input valid, ready, drive_pin, busy_mode, received_byte, received_done);
endinterface

`default_nettype wire

[hdl/tplbt_core.sv]
`default_nettype none

module tplbt_core #(
  parameter int DATA_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire tplbt_pkg::item_t  item,
  output tplbt_pkg::result_t     res
);
  import tplbt_pkg::*;

  localparam int POS_W = ($clog2(DATA_BITS + 4) > 4) ? $clog2(DATA_BITS + 4) : 4;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DATA_BITS + 2);
  localparam logic [POS_W-1:0] SHIFT_LEN = POS_W'(SHIFT_W);

  logic [1:0]         mode_r,  mode_nxt;
  logic [POS_W-1:0]   pos_r,   pos_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic               even_r,  even_nxt;
  logic               drive_r, drive_nxt;
  logic               done;
  logic [POS_W-1:0]   idx;

  // data bit index within the frame
  assign idx = pos_r - POS_W'(2);

  // next state for one request
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    even_nxt  = even_r;
    drive_nxt = drive_r;
    done      = 1'b0;
    unique case (item.kind)
      KIND_TICK: begin
        even_nxt = ~even_r;
        if (even_r && mode_r == MODE_SEND) begin
          // transmit: high, low, data LSB first, low
          if (pos_r == '0) begin
            drive_nxt = 1'b1;
          end else if (pos_r == POS_W'(1)) begin
            drive_nxt = 1'b0;
          end else if (pos_r < LAST_POS) begin
            drive_nxt = (idx < SHIFT_LEN) ? shift_r[idx[SHIFT_IDX_W-1:0]] : 1'b0;
          end else begin
            drive_nxt = 1'b0;
            mode_nxt  = MODE_IDLE;
          end
          if (pos_r <= LAST_POS) begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end else if (!even_r && mode_r == MODE_RECV) begin
          // receive: power up, wait for start, sample inverted bits
          if (pos_r == '0) begin
            drive_nxt = 1'b1;
            pos_nxt   = POS_W'(1);
          end else if (pos_r == POS_W'(1)) begin
            if (item.line_pin) begin
              pos_nxt   = POS_W'(2);
              shift_nxt = '0;
            end
          end else if (pos_r < LAST_POS) begin
            if (idx < SHIFT_LEN) begin
              shift_nxt[idx[SHIFT_IDX_W-1:0]] = shift_r[idx[SHIFT_IDX_W-1:0]] | ~item.line_pin;
            end
            pos_nxt = pos_r + POS_W'(1);
          end else begin
            drive_nxt = 1'b0;
            mode_nxt  = MODE_IDLE;
            done      = 1'b1;
          end
        end
      end
      KIND_SEND: begin
        shift_nxt = item.send_byte;
        pos_nxt   = '0;
        mode_nxt  = MODE_SEND;
      end
      KIND_RECV: begin
        pos_nxt  = '0;
        mode_nxt = MODE_RECV;
      end
      default: begin
        // unused kind leaves the state alone
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      shift_r <= '0;
      even_r  <= 1'b1;
      drive_r <= 1'b0;
    end else if (en) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      even_r  <= even_nxt;
      drive_r <= drive_nxt;
    end
  end

  // result reflects the state after this request
  always_comb begin
    res.drive_pin     = drive_nxt;
    res.busy_mode     = mode_nxt;
    res.received_byte = shift_nxt;
    res.received_done = done;
  end

endmodule

`default_nettype wire

[hdl/two_phase_line_byte_transceiver.sv]
// Tick-driven byte transceiver for a shared power/data line.
// in_chan carries requests: kind 0 is a timer tick, kind 1 starts sending
// send_byte, kind 2 starts receiving; line_pin is the sensed pin level.
// out_chan returns exactly one result per request: the driver pin level,
// the transfer mode after the request, the shift register contents and a
// flag set on the tick that completes a reception.
// A request accepted on in_chan is captured in an input register; the core
// then updates the line state and loads the result register once that
// register is free or being drained, and out_chan offers the result from it.
// One request per cycle is sustained while out_chan is ready: the single
// state update per request sits between the input and result registers.
// When out_chan stalls, the result register holds and the input register
// keeps one further request; in_chan.ready then drops until out_chan drains.
// Reset (rst_n low, synchronous) empties both registers and returns the line
// to idle, even phase, driver low and a cleared shift register.
`default_nettype none

module two_phase_line_byte_transceiver #(
  parameter int DATA_BITS = 8
) (
  input wire logic   clk,
  input wire logic   rst_n,
  tplbt_in_if.sink   in_chan,
  tplbt_out_if.source out_chan
);
  import tplbt_pkg::*;

  item_t   in_r;
  logic    in_vld_r;
  result_t out_r;
  logic    out_vld_r;
  result_t res;
  logic    advance;
  logic    take;

  // result register free or being drained
  assign advance = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !in_vld_r || advance;
  assign take = in_chan.valid && in_chan.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_r.kind      <= in_chan.kind;
      in_r.send_byte <= in_chan.send_byte;
      in_r.line_pin  <= in_chan.line_pin;
    end
  end

  tplbt_core #(
    .DATA_BITS(DATA_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (in_vld_r && advance),
    .item  (in_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r && advance) begin
      out_r <= res;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.drive_pin     = out_r.drive_pin;
  assign out_chan.busy_mode     = out_r.busy_mode;
  assign out_chan.received_byte = out_r.received_byte;
  assign out_chan.received_done = out_r.received_done;

endmodule

`default_nettype wire

[hdl/tplbt_checker.sv]
`default_nettype none

module tplbt_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_drive_pin,
  input wire logic [1:0]                  out_busy_mode,
  input wire logic [tplbt_pkg::SHIFT_W-1:0] out_received_byte,
  input wire logic                        out_received_done
);
  import tplbt_pkg::*;

  // no result survives a reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a finished reception leaves the line idle with the driver low
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_received_done) |->
      (out_busy_mode == MODE_IDLE && !out_drive_pin))
    else $error("reception done while still busy");

  // draining the result side always frees the request side
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("request side stalled while results drain");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_drive_pin) && $stable(out_busy_mode)
       && $stable(out_received_byte) && $stable(out_received_done)))
    else $error("stalled result changed");

endmodule

bind two_phase_line_byte_transceiver tplbt_checker u_tplbt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_drive_pin     (out_chan.drive_pin),
  .out_busy_mode     (out_chan.busy_mode),
  .out_received_byte (out_chan.received_byte),
  .out_received_done (out_chan.received_done)
);

`default_nettype wire

[tb/sv/two_phase_line_byte_transceiver_test.sv]
`default_nettype none

module two_phase_line_byte_transceiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tplbt_pkg::*;

  localparam int         DATA_BITS    = 8;
  localparam logic [4:0] FRAME_END    = 5'(2 + DATA_BITS);
  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         RANDOM_REQS  = 450;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst_n = 1'b0;

  tplbt_in_if  in_chan ();
  tplbt_out_if out_chan ();

  two_phase_line_byte_transceiver #(
    .DATA_BITS(DATA_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // line state as the transceiver should hold it
  logic [1:0]         line_mode = MODE_IDLE;
  logic [4:0]         bit_pos   = '0;
  logic [SHIFT_W-1:0] shift_reg = '0;
  logic               even_tick = 1'b1;
  logic               drive_lvl = 1'b0;

  item_t   pending_reqs[$];
  result_t expected_lines[$];
  item_t   next_req;
  result_t want_line;

  int  total_reqs   = 0;
  int  results_seen = 0;
  int  fault_count  = 0;
  int  cycle_count  = 0;
  int  send_gap     = 0;
  int  stall_left   = 0;
  bit  quiet        = 1'b0;
  bit  req_taken    = 1'b0;

  // advance the line state by one request and return what it reports
  function automatic result_t line_step(input item_t r);
    result_t    res;
    logic       done;
    logic [4:0] idx;
    logic [15:0] wide;
    done = 1'b0;
    idx  = bit_pos - 5'd2;
    wide = {8'b0, shift_reg};
    case (r.kind)
      KIND_TICK: begin
        if (even_tick) begin
          // transmit side moves on even ticks
          if (line_mode == MODE_SEND) begin
            if (bit_pos == 5'd0) begin
              drive_lvl = 1'b1;
            end else if (bit_pos == 5'd1) begin
              drive_lvl = 1'b0;
            end else if (bit_pos < FRAME_END) begin
              drive_lvl = wide[idx[3:0]];
            end else begin
              drive_lvl = 1'b0;
              line_mode = MODE_IDLE;
            end
            if (bit_pos <= FRAME_END) bit_pos = bit_pos + 5'd1;
          end
        end else if (line_mode == MODE_RECV) begin
          // receive side moves on odd ticks
          if (bit_pos == 5'd0) begin
            drive_lvl = 1'b1;
            bit_pos   = 5'd1;
          end else if (bit_pos == 5'd1) begin
            if (r.line_pin) begin
              bit_pos   = 5'd2;
              shift_reg = '0;
            end
          end else if (bit_pos < FRAME_END) begin
            // pin is inverted; bits past the register width fall away
            if (idx < 5'(SHIFT_W)) shift_reg[idx[2:0]] = shift_reg[idx[2:0]] | ~r.line_pin;
            bit_pos = bit_pos + 5'd1;
          end else begin
            drive_lvl = 1'b0;
            line_mode = MODE_IDLE;
            done      = 1'b1;
          end
        end
        even_tick = ~even_tick;
      end
      KIND_SEND: begin
        shift_reg = r.send_byte;
        bit_pos   = '0;
        line_mode = MODE_SEND;
      end
      KIND_RECV: begin
        bit_pos   = '0;
        line_mode = MODE_RECV;
      end
      default: begin
      end
    endcase
    res.drive_pin     = drive_lvl;
    res.busy_mode     = line_mode;
    res.received_byte = shift_reg;
    res.received_done = done;
    return res;
  endfunction

  task automatic push_req(input logic [1:0] kind, input logic [7:0] byte_val,
                          input logic pin);
    item_t r;
    r.kind      = kind;
    r.send_byte = byte_val;
    r.line_pin  = pin;
    pending_reqs.push_back(r);
    total_reqs++;
  endtask

  // send command then a run of ticks; a short run leaves the frame to be overridden
  task automatic queue_send_frame(input logic [7:0] byte_val, input bit full);
    int ticks;
    ticks = full ? 23 : $urandom_range(1, 19);
    push_req(KIND_SEND, byte_val, 1'($urandom));
    repeat (ticks) push_req(KIND_TICK, 8'($urandom), 1'($urandom));
  endtask

  // receive command, a wait with the pin low, a start bit, then data
  // pin_mode: 0 random data, 1 pin held low (all ones), 2 pin held high (all zeros)
  task automatic queue_recv_frame(input int pin_mode, input bit full);
    int   waits;
    int   data_ticks;
    logic pin;
    waits      = $urandom_range(0, 6);
    data_ticks = full ? 20 : $urandom_range(1, 19);
    push_req(KIND_RECV, 8'($urandom), 1'($urandom));
    repeat (2) push_req(KIND_TICK, 8'($urandom), 1'($urandom));
    repeat (waits) push_req(KIND_TICK, 8'($urandom), 1'b0);
    repeat (2) push_req(KIND_TICK, 8'($urandom), 1'b1);
    repeat (data_ticks) begin
      pin = (pin_mode == 0) ? 1'($urandom) : (pin_mode == 2);
      push_req(KIND_TICK, 8'($urandom), pin);
    end
  endtask

  // request driver: holds a request until taken, idles in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (in_chan.valid && !req_taken) begin
      // request still waiting for ready
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      in_chan.valid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      send_gap = $urandom_range(0, 6);
      in_chan.valid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      next_req = pending_reqs.pop_front();
      in_chan.kind      <= next_req.kind;
      in_chan.send_byte <= next_req.send_byte;
      in_chan.line_pin  <= next_req.line_pin;
      in_chan.valid     <= 1'b1;
    end else begin
      in_chan.valid <= 1'b0;
    end
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_chan.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    req_taken <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      next_req.kind      = in_chan.kind;
      next_req.send_byte = in_chan.send_byte;
      next_req.line_pin  = in_chan.line_pin;
      expected_lines.push_back(line_step(next_req));
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (expected_lines.size() == 0) begin
        $error("result with no request outstanding");
        fault_count++;
      end else begin
        want_line = expected_lines.pop_front();
        if (out_chan.drive_pin !== want_line.drive_pin) begin
          $error("drive_pin: expected %0d, got %0d", want_line.drive_pin, out_chan.drive_pin);
          fault_count++;
        end
        if (out_chan.busy_mode !== want_line.busy_mode) begin
          $error("busy_mode: expected %0d, got %0d", want_line.busy_mode, out_chan.busy_mode);
          fault_count++;
        end
        if (out_chan.received_byte !== want_line.received_byte) begin
          $error("received_byte: expected %0h, got %0h",
                 want_line.received_byte, out_chan.received_byte);
          fault_count++;
        end
        if (out_chan.received_done !== want_line.received_done) begin
          $error("received_done: expected %0d, got %0d",
                 want_line.received_done, out_chan.received_done);
          fault_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timed out after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int directed_count;
    int pick;
    in_chan.valid     = 1'b0;
    in_chan.kind      = KIND_TICK;
    in_chan.send_byte = '0;
    in_chan.line_pin  = 1'b0;
    out_chan.ready    = 1'b0;

    // unknown kind at reset, idle ticks on both phases
    push_req(KIND_UNUSED, 8'hFF, 1'b1);
    push_req(KIND_TICK, 8'h00, 1'b0);
    push_req(KIND_TICK, 8'hFF, 1'b1);
    // send, unknown kind mid-frame, then override by another send
    push_req(KIND_SEND, 8'hFF, 1'b0);
    push_req(KIND_UNUSED, 8'h00, 1'b0);
    push_req(KIND_TICK, 8'h00, 1'b0);
    push_req(KIND_TICK, 8'h00, 1'b1);
    push_req(KIND_TICK, 8'h00, 1'b0);
    push_req(KIND_SEND, 8'h00, 1'b1);
    push_req(KIND_TICK, 8'h00, 1'b0);
    push_req(KIND_TICK, 8'h00, 1'b0);
    // receive overrides send; start bit right after power-up, then data bits
    push_req(KIND_RECV, 8'h00, 1'b0);
    push_req(KIND_TICK, 8'h00, 1'b1);
    push_req(KIND_TICK, 8'h00, 1'b0);
    push_req(KIND_TICK, 8'h00, 1'b1);
    push_req(KIND_TICK, 8'h00, 1'b0);
    push_req(KIND_TICK, 8'h00, 1'b1);
    push_req(KIND_TICK, 8'h00, 1'b0);
    push_req(KIND_TICK, 8'h00, 1'b0);
    push_req(KIND_TICK, 8'h00, 1'b1);
    push_req(KIND_TICK, 8'h00, 1'b1);
    push_req(KIND_TICK, 8'h00, 1'b0);
    // send overrides a reception in progress
    push_req(KIND_SEND, 8'hA5, 1'b0);
    push_req(KIND_UNUSED, 8'h5A, 1'b1);
    directed_count = total_reqs;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // hold off until every directed result is back
    while (results_seen != total_reqs) @(negedge clk);
    @(posedge clk);

    // full frames at the byte extremes
    queue_send_frame(8'hFF, 1'b1);
    queue_send_frame(8'h00, 1'b1);
    queue_recv_frame(1, 1'b1);
    queue_recv_frame(2, 1'b1);

    // mostly whole frames with random content, some cut short, some noise
    while (total_reqs < directed_count + RANDOM_REQS) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        queue_send_frame(8'($urandom), $urandom_range(0, 4) != 0);
      end else if (pick < 8) begin
        queue_recv_frame($urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : 0,
                         $urandom_range(0, 4) != 0);
      end else begin
        repeat ($urandom_range(1, 6))
          push_req(2'($urandom), 8'($urandom), 1'($urandom));
      end
    end

    // last stretch runs without idling on either side
    while (pending_reqs.size() > 60) @(posedge clk);
    quiet = 1'b1;

    while (results_seen != total_reqs) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_lines.size() != 0) begin
      $error("%0d results never arrived", expected_lines.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
